### rtl/bmp_stream_decoder_macros.svh
// Assertion macros shared by the decoder RTL
`ifndef BMP_STREAM_DECODER_MACROS_SVH
`define BMP_STREAM_DECODER_MACROS_SVH

// check that an antecedent implies a consequent in the same cycle
`define BMP_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("assertion failed");

// check that an antecedent implies a consequent in the next cycle
`define BMP_ASSERT_NXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

### rtl/bmpd_pkg.sv
// Package with types and constants of the BMP stream decoder
package bmpd_pkg;

  localparam int unsigned MaxWidth     = 4096;
  localparam int unsigned MaxHeight    = 4096;
  localparam int unsigned PaletteDepth = 256;
  localparam int unsigned PalAw        = $clog2(PaletteDepth);

  typedef enum logic [2:0] {
    PhHeader  = 3'd0,
    PhPalette = 3'd1,
    PhSkip    = 3'd2,
    PhData    = 3'd3,
    PhDone    = 3'd4
  } phase_e;

  typedef enum logic [1:0] {
    KindPixel  = 2'd0,
    KindHeader = 2'd1,
    KindError  = 2'd2
  } kind_e;

  typedef enum logic [1:0] {
    Bpp1 = 2'd0,
    Bpp3 = 2'd1,
    Bpp4 = 2'd2
  } bpp_mode_e;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       start_of_file;
  } in_item_t;

  typedef struct packed {
    logic [1:0]  kind;
    logic [11:0] pixel_x;
    logic [11:0] pixel_y;
    logic [7:0]  alpha;
    logic [7:0]  red;
    logic [7:0]  green;
    logic [7:0]  blue;
    logic [12:0] image_width;
    logic [12:0] image_height;
    logic        last;
  } out_item_t;

  // palette write request from the parser to the palette memory
  typedef struct packed {
    logic             we;
    logic [PalAw-1:0] waddr;
    logic [23:0]      wdata;
  } pal_wr_t;

endpackage

### rtl/bmp_stream_decoder.sv
// Top level of the streaming BMP decoder
//
//  channel | valid      | stall      | payload
//  input   | in_valid_i | in_stall_o | in_item_i  (bmpd_pkg::in_item_t)
//  output  | out_valid_o| out_stall_i| out_item_o (bmpd_pkg::out_item_t)
//
// One byte a cycle is taken while the input is not stalled. An 8-bit pixel
// reads the palette memory, whose read is registered: every result waits in
// stage 1, then moves to the output register, where palette data joins it.
// Reset clears all control state; the palette is undefined until loaded.
// A stalled output holds both stages; input is stalled whenever the output
// register holds a result that is stalled.
`include "bmp_stream_decoder_macros.svh"
module bmp_stream_decoder (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  bmpd_pkg::in_item_t  in_item_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output bmpd_pkg::out_item_t out_item_o
);

  // parse state
  bmpd_pkg::phase_e phase_q, phase_d;
  logic [31:0] cnt_q, cnt_d, fa_q, fa_d, off_q, off_d, pleft_q, pleft_d;
  logic [12:0] wid_q, wid_d, hgt_q, hgt_d;
  logic        td_q, td_d, bad_q, bad_d;
  logic [1:0]  mode_q, mode_d;
  logic [8:0]  pcnt_q, pcnt_d, pfill_q, pfill_d;
  logic [15:0] bpp_q, bpp_d;
  logic [1:0]  psub_q, psub_d;
  logic [11:0] col_q, col_d, row_q, row_d;
  logic [14:0] rbc_q, rbc_d;
  logic [1:0]  kpix_q, kpix_d;
  logic [23:0] hold_q, hold_d;
  logic [14:0] rowb_q, rowb_d;

  // stage 1: result waiting for palette data
  logic                s1_v_q, s1_v_d, s1_pal_q, s1_pal_d;
  bmpd_pkg::out_item_t s1_q, s1_d;
  // output register
  logic                o_v_q;
  bmpd_pkg::out_item_t o_q;

  bmpd_pkg::pal_wr_t   pwr;
  logic [23:0]         prd;
  logic                adv, acc;

  // pipeline moves when output can take stage 1
  assign adv        = !o_v_q || !out_stall_i;
  assign in_stall_o = !adv;
  assign acc        = in_valid_i && adv;

  bmpd_palette u_pal (
    .clk_i  (clk_i),
    .wr_i   (pwr),
    .re_i   (acc),
    .raddr_i(in_item_i.data_byte),
    .rdata_o(prd)
  );

  function automatic bmpd_pkg::out_item_t pix(input logic [11:0] x, input logic [11:0] y,
                                             input logic [7:0] a, input logic [23:0] rgb,
                                             input logic lst);
    bmpd_pkg::out_item_t r;
    r              = '0;
    r.kind         = bmpd_pkg::KindPixel;
    r.pixel_x      = x;
    r.pixel_y      = y;
    r.alpha        = a;
    r.red          = rgb[23:16];
    r.green        = rgb[15:8];
    r.blue         = rgb[7:0];
    r.last         = lst;
    return r;
  endfunction

  always_comb begin
    logic [7:0]  b;
    logic [31:0] pos, v, mag, fw;
    logic [11:0] y;
    logic        lst, newrow;
    logic [14:0] rb;
    logic [15:0] bits;
    logic [31:0] pe;
    phase_d = phase_q; cnt_d = cnt_q; fa_d = fa_q; off_d = off_q; pleft_d = pleft_q;
    wid_d = wid_q; hgt_d = hgt_q; td_d = td_q; bad_d = bad_q; mode_d = mode_q;
    pcnt_d = pcnt_q; pfill_d = pfill_q; bpp_d = bpp_q; psub_d = psub_q;
    col_d = col_q; row_d = row_q; rbc_d = rbc_q; kpix_d = kpix_q; hold_d = hold_q;
    rowb_d = rowb_q;
    s1_v_d = 1'b0; s1_pal_d = 1'b0; s1_d = '0;
    pwr = '0;
    b = in_item_i.data_byte;
    pos = '0; v = '0; mag = '0; fw = '0; y = '0; lst = 1'b0; newrow = 1'b0;
    rb = '0; bits = '0; pe = '0;
    if (acc) begin
      if (in_item_i.start_of_file) begin
        phase_d = bmpd_pkg::PhHeader; cnt_d = '0; fa_d = '0; off_d = '0; pleft_d = '0;
        wid_d = '0; hgt_d = '0; td_d = 1'b0; bad_d = 1'b0; mode_d = '0; pcnt_d = '0;
        pfill_d = '0; bpp_d = '0; psub_d = '0; col_d = '0; row_d = '0; rbc_d = '0;
        kpix_d = '0; hold_d = '0; rowb_d = '0;
      end
      pos = cnt_d;
      if (cnt_d != 32'hFFFF_FFFF) cnt_d = cnt_d + 32'd1;
      y   = td_d ? row_d : 12'(hgt_d - 13'd1 - {1'b0, row_d});
      lst = ({1'b0, col_d} + 13'd1 == wid_d) && ({1'b0, row_d} + 13'd1 == hgt_d);
      case (phase_d)
        bmpd_pkg::PhHeader: begin
          v = {b, fa_d[31:8]};
          fa_d = v;
          if (pos == 32'd13) off_d = v;
          else if (pos == 32'd21) begin
            if (v >= 32'd1 && v <= 32'(bmpd_pkg::MaxWidth)) wid_d = v[12:0];
            else begin wid_d = '0; bad_d = 1'b1; end
          end else if (pos == 32'd25) begin
            td_d = v[31];
            mag  = v[31] ? (~v) + 32'd1 : v;
            if (mag >= 32'd1 && mag <= 32'(bmpd_pkg::MaxHeight)) hgt_d = mag[12:0];
            else begin hgt_d = '0; bad_d = 1'b1; end
          end else if (pos == 32'd29) bpp_d = v[31:16];
          else if (pos == 32'd33) begin
            if (v != 32'd0) bad_d = 1'b1;
          end else if (pos == 32'd49) pleft_d = v;
          else if (pos == 32'd53) begin
            s1_v_d = 1'b1;
            if (bpp_d == 16'd8) begin
              mode_d = bmpd_pkg::Bpp1; bits = 16'd8;
            end else if (bpp_d == 16'd24) begin
              mode_d = bmpd_pkg::Bpp3; bits = 16'd24;
            end else if (bpp_d == 16'd32) begin
              mode_d = bmpd_pkg::Bpp4; bits = 16'd32;
            end else bad_d = 1'b1;
            if (bad_d) begin
              phase_d = bmpd_pkg::PhDone;
              s1_d.kind = bmpd_pkg::KindError;
              s1_d.last = 1'b1;
            end else begin
              pe = (bpp_d == 16'd8 && pleft_d == 32'd0) ? 32'(bmpd_pkg::PaletteDepth)
                                                        : pleft_d;
              pleft_d = pe;
              pcnt_d = (pe > 32'(bmpd_pkg::PaletteDepth)) ? 9'(bmpd_pkg::PaletteDepth)
                                                           : pe[8:0];
              // row bytes: (bits*width + 31)/32*4
              fw = 32'(bits) * 32'(wid_d) + 32'd31;
              rowb_d = {fw[17:5], 2'b00};
              s1_d.kind = bmpd_pkg::KindHeader;
              s1_d.image_width = wid_d;
              s1_d.image_height = hgt_d;
              if (pe == 32'd0) begin
                phase_d = (cnt_d >= off_d) ? bmpd_pkg::PhData : bmpd_pkg::PhSkip;
              end else phase_d = bmpd_pkg::PhPalette;
            end
          end
        end
        bmpd_pkg::PhPalette: begin
          if (psub_d != 2'd3) begin
            hold_d = (psub_d == 2'd0) ? 24'd0 : hold_d;
            hold_d = hold_d | (24'(b) << (5'd8 * {3'd0, psub_d}));
            psub_d = psub_d + 2'd1;
          end else begin
            if (pfill_d < 9'(bmpd_pkg::PaletteDepth)) begin
              pwr.we = 1'b1;
              pwr.waddr = pfill_d[bmpd_pkg::PalAw-1:0];
              pwr.wdata = hold_d;
              pfill_d = pfill_d + 9'd1;
            end
            psub_d = '0;
            pleft_d = pleft_d - 32'd1;
          end
          if (pleft_d == 32'd0) begin
            phase_d = (cnt_d >= off_d) ? bmpd_pkg::PhData : bmpd_pkg::PhSkip;
          end
        end
        bmpd_pkg::PhSkip: begin
          if (cnt_d >= off_d) phase_d = bmpd_pkg::PhData;
        end
        bmpd_pkg::PhData: begin
          if ({1'b0, col_d} < wid_d) begin
            if (mode_d == bmpd_pkg::Bpp1) begin
              s1_v_d = 1'b1;
              s1_pal_d = ({1'b0, b} < pcnt_d);
              s1_d = pix(col_d, y, 8'd0, 24'd0, lst);
              col_d = col_d + 12'd1;
            end else begin
              if (kpix_d != 2'd3) begin
                hold_d = (kpix_d == 2'd0) ? 24'd0 : hold_d;
                hold_d = hold_d | (24'(b) << (5'd8 * {3'd0, kpix_d}));
              end
              if ((mode_d == bmpd_pkg::Bpp3 && kpix_d == 2'd2) || kpix_d == 2'd3) begin
                s1_v_d = 1'b1;
                s1_d = pix(col_d, y, (kpix_d == 2'd3) ? b : 8'hFF, hold_d, lst);
                col_d = col_d + 12'd1;
                kpix_d = '0;
              end else kpix_d = kpix_d + 2'd1;
            end
          end
          rb = rbc_d + 15'd1;
          rbc_d = rb;
          newrow = (rb >= rowb_d);
          if (newrow) begin
            rbc_d = '0; col_d = '0; kpix_d = '0;
            // compare before the increment so the last row of a full-height image ends
            if ({1'b0, row_d} + 13'd1 >= hgt_d) phase_d = bmpd_pkg::PhDone;
            row_d = row_d + 12'd1;
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= bmpd_pkg::PhHeader;
      cnt_q <= '0; fa_q <= '0; off_q <= '0; pleft_q <= '0; wid_q <= '0; hgt_q <= '0;
      td_q <= 1'b0; bad_q <= 1'b0; mode_q <= '0; pcnt_q <= '0; pfill_q <= '0;
      bpp_q <= '0; psub_q <= '0; col_q <= '0; row_q <= '0; rbc_q <= '0; kpix_q <= '0;
      hold_q <= '0; rowb_q <= '0;
      s1_v_q <= 1'b0; s1_pal_q <= 1'b0; o_v_q <= 1'b0;
    end else begin
      phase_q <= phase_d; cnt_q <= cnt_d; fa_q <= fa_d; off_q <= off_d;
      pleft_q <= pleft_d; wid_q <= wid_d; hgt_q <= hgt_d; td_q <= td_d; bad_q <= bad_d;
      mode_q <= mode_d; pcnt_q <= pcnt_d; pfill_q <= pfill_d; bpp_q <= bpp_d;
      psub_q <= psub_d; col_q <= col_d; row_q <= row_d; rbc_q <= rbc_d;
      kpix_q <= kpix_d; hold_q <= hold_d; rowb_q <= rowb_d;
      if (adv) begin
        s1_v_q   <= s1_v_d;
        s1_pal_q <= s1_pal_d;
        o_v_q    <= s1_v_q;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (adv) begin
      s1_q <= s1_d;
      o_q  <= s1_q;
      if (s1_pal_q) begin
        o_q.alpha <= 8'hFF;
        o_q.red   <= prd[23:16];
        o_q.green <= prd[15:8];
        o_q.blue  <= prd[7:0];
      end
    end
  end

  assign out_valid_o = o_v_q;
  assign out_item_o  = o_q;

  `BMP_ASSERT_IMP(a_stall_only_full, clk_i, rst_ni, in_stall_o, out_valid_o && out_stall_i)
  `BMP_ASSERT_NXT(a_out_hold, clk_i, rst_ni, out_valid_o && out_stall_i,
                  out_valid_o && $stable(out_item_o))
  `BMP_ASSERT_IMP(a_pal_in_data, clk_i, rst_ni, s1_pal_q, s1_v_q)
  `BMP_ASSERT_IMP(a_err_last, clk_i, rst_ni,
                  out_valid_o && out_item_o.kind == bmpd_pkg::KindError, out_item_o.last)

endmodule

### rtl/bmpd_palette.sv
// Palette memory with one write and one registered read port
module bmpd_palette (
  input  logic                        clk_i,
  input  bmpd_pkg::pal_wr_t           wr_i,
  input  logic                        re_i,
  input  logic [bmpd_pkg::PalAw-1:0]  raddr_i,
  output logic [23:0]                 rdata_o
);

  logic [23:0] mem_q [bmpd_pkg::PaletteDepth];
  logic [23:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (wr_i.we) begin
      mem_q[wr_i.waddr] <= wr_i.wdata;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

### sim/bmp_stream_decoder_test.sv
// Self-checking testbench for the streaming BMP decoder
module bmp_stream_decoder_test;
  timeunit 1ns;
  timeprecision 1ps;

  // Mirror of the decoder's parse state; predicts the header, error and pixel results
  class bmp_scoreboard;
    bmpd_pkg::phase_e    phase;
    logic [31:0]         pos_count, shifter, data_offset, entries_left;
    logic [12:0]         width, height;
    logic                top_down, bad;
    bmpd_pkg::bpp_mode_e mode;
    logic [15:0]         bits_pp;
    logic [8:0]          pal_count;
    logic [31:0]         pal_fill;
    logic [1:0]          pal_byte;
    logic [23:0]         palette [bmpd_pkg::PaletteDepth];
    logic [11:0]         col, row;
    logic [14:0]         row_byte;
    logic [23:0]         hold;
    bmpd_pkg::out_item_t pending[$];
    int                  errors;

    function void restart();
      phase = bmpd_pkg::PhHeader; pos_count = 0; shifter = 0; data_offset = 0;
      width = 0; height = 0; top_down = 0; bad = 0; mode = bmpd_pkg::Bpp1; bits_pp = 0;
      pal_count = 0; entries_left = 0; pal_fill = 0; pal_byte = 0;
      col = 0; row = 0; row_byte = 0; hold = 0;
    endfunction

    function void settle();
      if (phase == bmpd_pkg::PhPalette && entries_left == 0) phase = bmpd_pkg::PhSkip;
      if (phase == bmpd_pkg::PhSkip && pos_count >= data_offset) phase = bmpd_pkg::PhData;
    endfunction

    function void push_pixel(logic [7:0] a, logic [23:0] rgb);
      bmpd_pkg::out_item_t r;
      r = '0;
      r.kind = bmpd_pkg::KindPixel;
      r.pixel_x = col;
      r.pixel_y = top_down ? row : 12'(height - 13'd1 - 13'(row));
      r.alpha = a;
      r.red = rgb[23:16]; r.green = rgb[15:8]; r.blue = rgb[7:0];
      r.last = (13'(col) + 1 == width) && (13'(row) + 1 == height);
      pending.push_back(r);
    endfunction

    function void note_byte(bmpd_pkg::in_item_t it);
      logic [31:0]         pos, mag, bpb, row_len, k;
      logic [7:0]          b;
      bmpd_pkg::out_item_t r;
      b = it.data_byte;
      if (it.start_of_file) restart();
      pos = pos_count;
      if (pos_count != 32'hFFFF_FFFF) pos_count++;
      case (phase)
        bmpd_pkg::PhHeader: begin
          shifter = {b, shifter[31:8]};
          if (pos == 13) data_offset = shifter;
          else if (pos == 21) begin
            if (shifter >= 1 && shifter <= bmpd_pkg::MaxWidth) width = 13'(shifter);
            else begin width = 0; bad = 1; end
          end else if (pos == 25) begin
            top_down = shifter[31];
            mag = shifter[31] ? -shifter : shifter;
            if (mag >= 1 && mag <= bmpd_pkg::MaxHeight) height = 13'(mag);
            else begin height = 0; bad = 1; end
          end else if (pos == 29) bits_pp = shifter[31:16];
          else if (pos == 33) begin
            if (shifter != 0) bad = 1;
          end else if (pos == 49) entries_left = shifter;
          else if (pos == 53) begin
            if (bits_pp == 8) mode = bmpd_pkg::Bpp1;
            else if (bits_pp == 24) mode = bmpd_pkg::Bpp3;
            else if (bits_pp == 32) mode = bmpd_pkg::Bpp4;
            else bad = 1;
            r = '0;
            if (bad) begin
              phase = bmpd_pkg::PhDone;
              r.kind = bmpd_pkg::KindError; r.last = 1;
            end else begin
              if (bits_pp == 8 && entries_left == 0) entries_left = 256;
              pal_count = entries_left > bmpd_pkg::PaletteDepth ?
                          9'(bmpd_pkg::PaletteDepth) : 9'(entries_left);
              phase = bmpd_pkg::PhPalette;
              settle();
              r.kind = bmpd_pkg::KindHeader; r.image_width = width; r.image_height = height;
            end
            pending.push_back(r);
          end
        end
        bmpd_pkg::PhPalette: begin
          if (pal_byte < 3) begin
            if (pal_byte == 0) hold = 0;
            hold = hold | (24'(b) << (8 * pal_byte));
            pal_byte++;
          end else begin
            if (pal_fill < bmpd_pkg::PaletteDepth) begin
              palette[pal_fill[7:0]] = hold;
              pal_fill++;
            end
            pal_byte = 0;
            entries_left--;
          end
          settle();
        end
        bmpd_pkg::PhSkip: settle();
        bmpd_pkg::PhData: begin
          bpb = mode == bmpd_pkg::Bpp1 ? 1 : (mode == bmpd_pkg::Bpp3 ? 3 : 4);
          row_len = (bpb * 8 * width + 31) / 32 * 4;
          if (13'(col) < width) begin
            k = 32'(row_byte) - 32'(col) * bpb;
            if (bpb == 1) begin
              if (b < pal_count) push_pixel(8'hFF, palette[b]);
              else push_pixel(8'h00, 24'h0);
              col++;
            end else begin
              if (k < 3) begin
                if (k == 0) hold = 0;
                hold = hold | (24'(b) << (8 * k));
              end
              if (k == bpb - 1) begin
                push_pixel(bpb == 4 ? b : 8'hFF, hold);
                col++;
              end
            end
          end
          row_byte++;
          if (32'(row_byte) >= row_len) begin
            row_byte = 0; col = 0;
            if (32'(row) + 1 >= 32'(height)) phase = bmpd_pkg::PhDone;
            row++;
          end
        end
        default: ;
      endcase
    endfunction

    function void check_result(bmpd_pkg::out_item_t got);
      bmpd_pkg::out_item_t want;
      if (pending.size() == 0) begin
        $display("%0t: unexpected result %h", $realtime, got);
        errors++;
        return;
      end
      want = pending.pop_front();
      if (got !== want) begin
        $display("%0t: mismatch expected %h actual %h", $realtime, want, got);
        if (got.kind !== want.kind)
          $display("  kind expected %0d actual %0d", want.kind, got.kind);
        if (got.pixel_x !== want.pixel_x || got.pixel_y !== want.pixel_y)
          $display("  xy expected %0d,%0d actual %0d,%0d", want.pixel_x, want.pixel_y,
                   got.pixel_x, got.pixel_y);
        if ({got.alpha, got.red, got.green, got.blue} !==
            {want.alpha, want.red, want.green, want.blue})
          $display("  argb expected %h actual %h",
                   {want.alpha, want.red, want.green, want.blue},
                   {got.alpha, got.red, got.green, got.blue});
        if (got.image_width !== want.image_width || got.image_height !== want.image_height)
          $display("  size expected %0d x %0d actual %0d x %0d", want.image_width,
                   want.image_height, got.image_width, got.image_height);
        if (got.last !== want.last)
          $display("  last expected %0d actual %0d", want.last, got.last);
        errors++;
      end
    endfunction
  endclass

  logic                clk_i = 1'b0;
  logic                rst_ni = 1'b0;
  logic                in_valid_i = 1'b0;
  logic                in_stall_o;
  bmpd_pkg::in_item_t  in_item_i = '0;
  logic                out_valid_o;
  logic                out_stall_i = 1'b0;
  bmpd_pkg::out_item_t out_item_o;

  bmp_scoreboard decode_sb = new();
  logic [7:0]    file_bytes[$];
  logic          long_hold = 1'b0;
  int            idle_cycles = 0;

  bmp_stream_decoder uut (.*);

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) decode_sb.check_result(out_item_o);
    if (rst_ni && in_valid_i && !in_stall_o) decode_sb.note_byte(in_item_i);
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles > 20000) begin
      $display("status: fail");
      $finish;
    end
  end

  // Receiver stall pattern: random duty, with a long hold-off when requested
  always @(posedge clk_i) begin
    if (long_hold) out_stall_i <= 1'b1;
    else out_stall_i <= ($urandom_range(0, 99) < 30);
  end

  initial begin
    #1;
    forever begin
      repeat ($urandom_range(200, 600)) @(posedge clk_i);
      long_hold = 1'b1;
      repeat ($urandom_range(60, 200)) @(posedge clk_i);
      long_hold = 1'b0;
    end
  end

  // Send the queued file; the first byte carries the start flag
  task automatic send_file();
    int burst, gap;
    burst = 0;
    gap = 0;
    for (int i = 0; i < file_bytes.size(); i++) begin
      if (burst == 0) begin
        gap = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 6) : 0;
        if (gap > 0) begin
          in_valid_i <= 1'b0;
          repeat (gap) @(posedge clk_i);
        end
        burst = $urandom_range(1, 40);
      end
      in_valid_i <= 1'b1;
      in_item_i.data_byte <= file_bytes[i];
      in_item_i.start_of_file <= (i == 0);
      @(posedge clk_i);
      while (in_stall_o) @(posedge clk_i);
      burst--;
    end
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    file_bytes.delete();
  endtask

  function automatic void put_le(int unsigned v, int n);
    for (int i = 0; i < n; i++) file_bytes.push_back(8'(v >> (8 * i)));
  endfunction

  // Build a header, palette, gap and pixel data; the pixel data may be cut short or run long
  task automatic build_file(int w, int h, int bpp, int colors, int pal_entries,
                            int gap, int compr, bit neg, int data_len, bit rand_hdr);
    int unsigned offset;
    int hv;
    offset = 54 + 4 * pal_entries + gap;
    if (gap < 0) offset = $urandom_range(0, 54);
    hv = neg ? -h : h;
    put_le(16'h4D42, 2); put_le($urandom, 4); put_le($urandom, 4);
    put_le(offset, 4); put_le(40, 4); put_le(w, 4); put_le(hv, 4);
    put_le($urandom, 2); put_le(bpp, 2); put_le(compr, 4);
    put_le($urandom, 4); put_le($urandom, 4); put_le($urandom, 4);
    put_le(colors, 4); put_le($urandom, 4);
    if (rand_hdr)
      for (int i = 0; i < 54; i++)
        if ($urandom_range(0, 9) == 0) file_bytes[i] = 8'($urandom);
    for (int i = 0; i < 4 * pal_entries + (gap > 0 ? gap : 0) + data_len; i++)
      file_bytes.push_back($urandom_range(0, 3) == 0 ? 8'hFF :
                           ($urandom_range(0, 3) == 0 ? 8'h00 : 8'($urandom)));
    send_file();
  endtask

  function automatic int data_size(int w, int h, int bpp);
    return ((bpp * w + 31) / 32) * 4 * h;
  endfunction

  task automatic random_file();
    int w, h, bpp, colors, pal, sel;
    w = ($urandom_range(0, 9) == 0) ? $urandom_range(1, 9) : $urandom_range(1, 5);
    h = $urandom_range(1, 4);
    sel = $urandom_range(0, 2);
    bpp = sel == 0 ? 8 : (sel == 1 ? 24 : 32);
    colors = (bpp == 8) ? $urandom_range(1, 12) : $urandom_range(0, 2);
    pal = colors;
    if ($urandom_range(0, 9) == 0)
      build_file(w, h, $urandom_range(0, 40), colors, 0, 0, $urandom_range(0, 1),
                 $urandom_range(0, 1), $urandom_range(0, 20), 1);
    else
      build_file(w, h, bpp, colors, pal, $urandom_range(0, 4) == 0 ? -1 : $urandom_range(0, 6),
                 0, $urandom_range(0, 1),
                 data_size(w, h, bpp) + ($urandom_range(0, 4) == 0 ? $urandom_range(0, 8) : 0)
                 - ($urandom_range(0, 6) == 0 ? $urandom_range(0, 3) : 0), 0);
  endtask

  initial begin
    int sent;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    // directed: extremes of size, every depth, rejections, short palette
    build_file(1, 1, 24, 0, 0, 0, 0, 0, 4, 0);
    build_file(2, 2, 32, 0, 0, 0, 0, 1, 16, 0);
    build_file(3, 2, 8, 2, 2, 3, 0, 0, 8, 0);
    build_file(4096, 1, 8, 1, 1, 0, 0, 0, 40, 0);
    // zero colour count: the palette phase must still be consuming these bytes
    build_file(1, 4096, 8, 0, 20, 0, 0, 1, 0, 0);
    build_file(0, 1, 24, 0, 0, 0, 0, 0, 4, 0);
    build_file(4097, 1, 24, 0, 0, 0, 0, 0, 4, 0);
    build_file(1, 4097, 24, 0, 0, 0, 0, 1, 4, 0);
    build_file(1, 0, 24, 0, 0, 0, 0, 0, 4, 0);
    build_file(2, 1, 16, 0, 0, 0, 0, 0, 4, 0);
    build_file(2, 1, 24, 0, 0, 0, 1, 0, 4, 0);
    // oversized palette, cut off by the next start of file
    build_file(2, 1, 8, 300, 10, 0, 0, 0, 0, 0);
    build_file(2, 1, 24, 0, 0, -1, 0, 0, 12, 0);
    sent = 0;
    while (sent < 6) begin
      random_file();
      sent++;
    end
    while (decode_sb.pending.size() != 0) @(posedge clk_i);
    repeat (10) @(posedge clk_i);
    if (decode_sb.errors == 0) $display("status: pass");
    else $display("status: fail");
    $finish;
  end
endmodule
